@@ rtl/single_wire_sensor_reader_macros.svh @@
// assertion macros for the single-wire sensor reader
`ifndef SINGLE_WIRE_SENSOR_READER_MACROS_SVH
`define SINGLE_WIRE_SENSOR_READER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define SWSR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define SWSR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWSR_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define SWSR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

@@ rtl/swsr_pkg.sv @@
package swsr_pkg;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PRE_HIGH   = 4'd1,
        PH_START_LOW  = 4'd2,
        PH_RELEASE    = 4'd3,
        PH_SETTLE     = 4'd4,
        PH_RESP_LOW   = 4'd5,
        PH_RESP_DELAY = 4'd6,
        PH_RESP_HIGH  = 4'd7,
        PH_BYTE_LOW   = 4'd8,
        PH_BYTE_LEAD  = 4'd9,
        PH_BIT_RISE   = 4'd10,
        PH_BIT_SAMPLE = 4'd11,
        PH_BIT_FALL   = 4'd12,
        PH_BIT_TAIL   = 4'd13
    } phase_t;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_PRE_HIGH   = 3'd0;
    localparam logic [2:0] REG_START_LOW  = 3'd1;
    localparam logic [2:0] REG_RELEASE    = 3'd2;
    localparam logic [2:0] REG_SETTLE     = 3'd3;
    localparam logic [2:0] REG_RESP_DELAY = 3'd4;
    localparam logic [2:0] REG_BYTE_LEAD  = 3'd5;
    localparam logic [2:0] REG_SAMPLE     = 3'd6;
    localparam logic [2:0] REG_BIT_TAIL   = 3'd7;

    // register reset values
    localparam logic [15:0] PRE_HIGH_RST   = 16'd1250;
    localparam logic [7:0]  START_LOW_RST  = 8'd20;
    localparam logic [7:0]  RELEASE_RST    = 8'd40;
    localparam logic [7:0]  SETTLE_RST     = 8'd10;
    localparam logic [7:0]  RESP_DELAY_RST = 8'd40;
    localparam logic [7:0]  BYTE_LEAD_RST  = 8'd35;
    localparam logic [7:0]  SAMPLE_RST     = 8'd70;
    localparam logic [7:0]  BIT_TAIL_RST   = 8'd10;

    // edge wait limit in ticks
    localparam logic [15:0] TIMEOUT_TICKS = 16'hFFFF;

    // bytes kept for the result
    localparam int KEPT_BYTES = 3;

endpackage

@@ rtl/single_wire_sensor_reader.sv @@
// one tick beat in, one result beat out per accepted beat; result is registered
// and valid on the cycle after the accepting edge
// throughput one beat per cycle; only a stalled output register holds off input
// aresetn (synchronous, active low) puts the sequencer in idle, clears counters,
// received bytes and timeout flag, and loads the register reset values
`include "single_wire_sensor_reader_macros.svh"

module single_wire_sensor_reader #(
    parameter int BYTE_COUNT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_request, [1] line_level
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] drive_enable, [1] drive_level, [2] busy_res,
                                   // [3] done_res, [11:4] first_byte, [19:12] second_byte,
                                   // [27:20] third_byte, [28] timeout_seen
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swsr_pkg::*;

    localparam int BYTE_IDX_W = (BYTE_COUNT > 1) ? $clog2(BYTE_COUNT) : 1;
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(BYTE_COUNT - 1);

    // configuration registers
    logic [15:0] pre_high_reg;
    logic [7:0]  start_low_reg;
    logic [7:0]  release_reg;
    logic [7:0]  settle_reg;
    logic [7:0]  resp_delay_reg;
    logic [7:0]  byte_lead_reg;
    logic [7:0]  sample_reg;
    logic [7:0]  bit_tail_reg;

    // sequencer state
    phase_t                phase_reg, phase_next;
    logic [15:0]           tick_reg, tick_next;
    logic [2:0]            bit_reg, bit_next;
    logic [BYTE_IDX_W-1:0] byte_reg, byte_next;
    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            rx_reg [KEPT_BYTES];
    logic [7:0]            rx_next [KEPT_BYTES];
    logic                  timeout_reg, timeout_next;
    logic                  done_next;

    // output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        drive_en_next;
    logic        drive_lvl_next;
    logic        busy_next;

    logic        s_accept;
    logic        start_req;
    logic        line_lvl;
    logic        cfg_write;

    // per-phase timing selection
    logic        is_wait;
    logic        want_level;
    logic [15:0] delay_limit;
    logic        step_done;
    logic        step_timeout;
    logic [15:0] tick_inc;
    logic [2:0]  byte_ext;

    assign start_req = s_tdata[0];
    assign line_lvl  = s_tdata[1];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign byte_ext  = 3'(byte_reg);
    assign tick_inc  = tick_reg + 16'd1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_high_reg   <= PRE_HIGH_RST;
            start_low_reg  <= START_LOW_RST;
            release_reg    <= RELEASE_RST;
            settle_reg     <= SETTLE_RST;
            resp_delay_reg <= RESP_DELAY_RST;
            byte_lead_reg  <= BYTE_LEAD_RST;
            sample_reg     <= SAMPLE_RST;
            bit_tail_reg   <= BIT_TAIL_RST;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_PRE_HIGH:   pre_high_reg   <= pwdata[15:0];
                REG_START_LOW:  start_low_reg  <= pwdata[7:0];
                REG_RELEASE:    release_reg    <= pwdata[7:0];
                REG_SETTLE:     settle_reg     <= pwdata[7:0];
                REG_RESP_DELAY: resp_delay_reg <= pwdata[7:0];
                REG_BYTE_LEAD:  byte_lead_reg  <= pwdata[7:0];
                REG_SAMPLE:     sample_reg     <= pwdata[7:0];
                REG_BIT_TAIL:   bit_tail_reg   <= pwdata[7:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[4:2])
            REG_PRE_HIGH:   prdata = 32'(pre_high_reg);
            REG_START_LOW:  prdata = 32'(start_low_reg);
            REG_RELEASE:    prdata = 32'(release_reg);
            REG_SETTLE:     prdata = 32'(settle_reg);
            REG_RESP_DELAY: prdata = 32'(resp_delay_reg);
            REG_BYTE_LEAD:  prdata = 32'(byte_lead_reg);
            REG_SAMPLE:     prdata = 32'(sample_reg);
            REG_BIT_TAIL:   prdata = 32'(bit_tail_reg);
        endcase
    end

    // delay length or awaited level of the current phase
    always_comb begin
        is_wait     = 1'b0;
        want_level  = 1'b0;
        delay_limit = 16'd0;
        unique case (phase_reg)
            PH_PRE_HIGH:   delay_limit = pre_high_reg;
            PH_START_LOW:  delay_limit = 16'(start_low_reg);
            PH_RELEASE:    delay_limit = 16'(release_reg);
            PH_SETTLE:     delay_limit = 16'(settle_reg);
            PH_RESP_DELAY: delay_limit = 16'(resp_delay_reg);
            PH_BYTE_LEAD:  delay_limit = 16'(byte_lead_reg);
            PH_BIT_SAMPLE: delay_limit = 16'(sample_reg);
            PH_BIT_TAIL:   delay_limit = 16'(bit_tail_reg);
            PH_RESP_LOW, PH_BYTE_LOW, PH_BIT_FALL: begin
                is_wait    = 1'b1;
                want_level = 1'b0;
            end
            PH_RESP_HIGH, PH_BIT_RISE: begin
                is_wait    = 1'b1;
                want_level = 1'b1;
            end
            default: delay_limit = 16'd0;
        endcase
    end

    // end of a delay or an edge wait on this tick
    always_comb begin
        step_timeout = is_wait && (line_lvl != want_level) && (tick_reg >= TIMEOUT_TICKS);
        if (is_wait) begin
            step_done = (line_lvl == want_level) || step_timeout;
        end else begin
            step_done = tick_reg >= delay_limit;
        end
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        tick_next    = step_done ? 16'd0 : tick_inc;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        rx_next      = rx_reg;
        timeout_next = timeout_reg || step_timeout;
        done_next    = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                tick_next = 16'd0;
                if (start_req) begin
                    bit_next     = 3'd0;
                    byte_next    = '0;
                    shift_next   = 8'd0;
                    timeout_next = 1'b0;
                    for (int j = 0; j < KEPT_BYTES; j++) begin
                        rx_next[j] = 8'd0;
                    end
                    phase_next = PH_PRE_HIGH;
                end
            end
            PH_PRE_HIGH:   if (step_done) phase_next = PH_START_LOW;
            PH_START_LOW:  if (step_done) phase_next = PH_RELEASE;
            PH_RELEASE:    if (step_done) phase_next = PH_SETTLE;
            PH_SETTLE:     if (step_done) phase_next = PH_RESP_LOW;
            PH_RESP_LOW:   if (step_done) phase_next = PH_RESP_DELAY;
            PH_RESP_DELAY: if (step_done) phase_next = PH_RESP_HIGH;
            PH_RESP_HIGH:  if (step_done) phase_next = PH_BYTE_LOW;
            PH_BYTE_LOW:   if (step_done) phase_next = PH_BYTE_LEAD;
            PH_BYTE_LEAD: begin
                if (step_done) begin
                    bit_next   = 3'd0;
                    shift_next = 8'd0;
                    phase_next = PH_BIT_RISE;
                end
            end
            PH_BIT_RISE:   if (step_done) phase_next = PH_BIT_SAMPLE;
            PH_BIT_SAMPLE: begin
                if (step_done) begin
                    // lsb-first: new bit enters at the top
                    shift_next = {line_lvl, shift_reg[7:1]};
                    phase_next = PH_BIT_FALL;
                end
            end
            PH_BIT_FALL:   if (step_done) phase_next = PH_BIT_TAIL;
            PH_BIT_TAIL: begin
                if (step_done) begin
                    if (bit_reg == 3'd7) begin
                        // byte complete: keep it if it has a slot
                        for (int j = 0; j < KEPT_BYTES; j++) begin
                            if (byte_ext == 3'(j)) begin
                                rx_next[j] = shift_reg;
                            end
                        end
                        bit_next = 3'd0;
                        if (byte_reg == LAST_BYTE) begin
                            byte_next  = '0;
                            done_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            byte_next  = byte_reg + 1'b1;
                            phase_next = PH_BYTE_LOW;
                        end
                    end else begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_BIT_RISE;
                    end
                end
            end
            default: begin
                tick_next  = 16'd0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // pin control and status from the new phase
    always_comb begin
        drive_en_next  = (phase_next == PH_PRE_HIGH) || (phase_next == PH_START_LOW) ||
                         (phase_next == PH_RELEASE);
        drive_lvl_next = (phase_next == PH_PRE_HIGH) || (phase_next == PH_RELEASE);
        busy_next      = phase_next != PH_IDLE;
    end

    // state update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= 16'd0;
            bit_reg     <= 3'd0;
            byte_reg    <= '0;
            shift_reg   <= 8'd0;
            timeout_reg <= 1'b0;
            for (int j = 0; j < KEPT_BYTES; j++) begin
                rx_reg[j] <= 8'd0;
            end
        end else if (s_accept) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            timeout_reg <= timeout_next;
            rx_reg      <= rx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'b000, timeout_next, rx_next[2], rx_next[1], rx_next[0],
                            done_next, busy_next, drive_lvl_next, drive_en_next};
        end
    end

    // checks
    `SWSR_ASSERT_NEXT(a_start_enters_pre_high, aclk, aresetn,
        s_accept && (phase_reg == PH_IDLE) && start_req, phase_reg == PH_PRE_HIGH,
        "start beat in idle did not begin the pre-high phase")
    `SWSR_ASSERT_NEXT(a_state_holds_without_beat, aclk, aresetn,
        !s_accept, $stable(phase_reg) && $stable(tick_reg),
        "sequencer moved without an accepted beat")
    `SWSR_ASSERT_IMP(a_done_ends_read, aclk, aresetn,
        m_tvalid_reg && m_tdata_reg[3], !m_tdata_reg[2] && (phase_reg == PH_IDLE),
        "done result while the read is still running")
    `SWSR_ASSERT_IMP(a_ready_when_empty, aclk, aresetn,
        !m_tvalid_reg, s_tready,
        "input stalled while the result register is empty")

endmodule

@@ bench/tb_single_wire_sensor_reader.sv @@
`timescale 1ns / 100ps

module tb_single_wire_sensor_reader;
    import swsr_pkg::*;

    localparam int BYTES_PER_READ = 3;
    localparam int RANDOM_TICKS   = 1150;
    localparam int HOLD_CYCLES    = 400;
    localparam int STUCK_LIMIT    = 4000;

    // one result beat as packed on m_tdata, lowest field last
    typedef struct packed {
        logic       timeout_seen;
        logic [7:0] third_byte;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
        logic       done_res;
        logic       busy_res;
        logic       drive_level;
        logic       drive_enable;
    } reading_t;

    // directed row: tick inputs, and a hand-written result where one is given
    typedef struct packed {
        bit       st;
        bit       ln;
        bit       typed;
        reading_t val;
    } row_t;

    // idle with nothing received
    localparam reading_t QUIET = '0;
    // busy, pin driven high, nothing received
    localparam reading_t DRIVE_HIGH = {1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [0] start_request, [1] line_level
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [0] drive_enable, [1] drive_level, [2] busy_res,
                                    // [3] done_res, [11:4] first_byte, [19:12] second_byte,
                                    // [27:20] third_byte, [28] timeout_seen
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    single_wire_sensor_reader #(
        .BYTE_COUNT(BYTES_PER_READ)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // sequencer mirror: timing registers and read state
    logic [15:0] cfg_val [8];
    phase_t      ph;
    logic [15:0] cnt;
    logic [2:0]  bit_idx;
    logic [1:0]  byte_idx;
    logic [7:0]  shreg;
    logic [7:0]  rx_bytes [KEPT_BYTES];
    logic        to_flag;

    reading_t reading_q [$];
    int       bad_beats = 0;

    // sender burst state and corner-case knobs
    int burst_left = 0;
    int gap_len;
    bit hold_req = 1'b0;

    // receiver pattern state
    logic [7:0] rx_cycle = '0;
    int         hold_left = 0;
    int         stuck_cycles = 0;

    string fld_name [9] = '{"drive_enable", "drive_level", "busy_res", "done_res",
                            "first_byte", "second_byte", "third_byte", "timeout_seen", "pad"};
    int    fld_lsb [9]  = '{0, 1, 2, 3, 4, 12, 20, 28, 29};
    int    fld_w [9]    = '{1, 1, 1, 1, 8, 8, 8, 1, 3};

    row_t plan [10] = '{
        {1'b0, 1'b0, 1'b1, QUIET},       // idle after reset, pin low
        {1'b0, 1'b1, 1'b1, QUIET},       // idle after reset, pin high
        {1'b1, 1'b1, 1'b1, DRIVE_HIGH},  // start from idle
        {1'b1, 1'b0, 1'b1, DRIVE_HIGH},  // start while busy is ignored
        {1'b0, 1'b1, 1'b1, DRIVE_HIGH},
        {1'b0, 1'b0, 1'b1, DRIVE_HIGH},
        {1'b1, 1'b1, 1'b0, QUIET},
        {1'b0, 1'b0, 1'b0, QUIET},
        {1'b1, 1'b0, 1'b0, QUIET},
        {1'b0, 1'b1, 1'b0, QUIET}
    };

    function automatic void goto_phase(input phase_t nxt);
        ph  = nxt;
        cnt = '0;
    endfunction

    // timed phase of lim+1 ticks
    function automatic bit delay_over(input logic [15:0] lim);
        if (cnt >= lim)
            return 1'b1;
        cnt = cnt + 16'd1;
        return 1'b0;
    endfunction

    // edge wait, gives up after the tick limit and flags it
    function automatic bit edge_seen(input bit ln, input bit want);
        if (ln == want)
            return 1'b1;
        if (cnt >= TIMEOUT_TICKS) begin
            to_flag = 1'b1;
            return 1'b1;
        end
        cnt = cnt + 16'd1;
        return 1'b0;
    endfunction

    // advance the mirror by one tick and form the result beat
    function automatic reading_t sensor_step(input bit st, input bit ln);
        reading_t r;
        bit       done;
        done = 1'b0;
        case (ph)
            PH_IDLE: begin
                if (st) begin
                    bit_idx  = '0;
                    byte_idx = '0;
                    shreg    = '0;
                    foreach (rx_bytes[i]) rx_bytes[i] = '0;
                    to_flag  = 1'b0;
                    goto_phase(PH_PRE_HIGH);
                end
            end
            PH_PRE_HIGH:   if (delay_over(cfg_val[REG_PRE_HIGH])) goto_phase(PH_START_LOW);
            PH_START_LOW:  if (delay_over(cfg_val[REG_START_LOW])) goto_phase(PH_RELEASE);
            PH_RELEASE:    if (delay_over(cfg_val[REG_RELEASE])) goto_phase(PH_SETTLE);
            PH_SETTLE:     if (delay_over(cfg_val[REG_SETTLE])) goto_phase(PH_RESP_LOW);
            PH_RESP_LOW:   if (edge_seen(ln, 1'b0)) goto_phase(PH_RESP_DELAY);
            PH_RESP_DELAY: if (delay_over(cfg_val[REG_RESP_DELAY])) goto_phase(PH_RESP_HIGH);
            PH_RESP_HIGH:  if (edge_seen(ln, 1'b1)) goto_phase(PH_BYTE_LOW);
            PH_BYTE_LOW:   if (edge_seen(ln, 1'b0)) goto_phase(PH_BYTE_LEAD);
            PH_BYTE_LEAD: begin
                if (delay_over(cfg_val[REG_BYTE_LEAD])) begin
                    bit_idx = '0;
                    shreg   = '0;
                    goto_phase(PH_BIT_RISE);
                end
            end
            PH_BIT_RISE:   if (edge_seen(ln, 1'b1)) goto_phase(PH_BIT_SAMPLE);
            PH_BIT_SAMPLE: begin
                // lsb-first: new bit enters at the top
                if (delay_over(cfg_val[REG_SAMPLE])) begin
                    shreg = {ln, shreg[7:1]};
                    goto_phase(PH_BIT_FALL);
                end
            end
            PH_BIT_FALL:   if (edge_seen(ln, 1'b0)) goto_phase(PH_BIT_TAIL);
            PH_BIT_TAIL: begin
                if (delay_over(cfg_val[REG_BIT_TAIL])) begin
                    if (bit_idx == 3'd7) begin
                        if (int'(byte_idx) < KEPT_BYTES)
                            rx_bytes[byte_idx] = shreg;
                        bit_idx = '0;
                        if (int'(byte_idx) + 1 >= BYTES_PER_READ) begin
                            byte_idx = '0;
                            done     = 1'b1;
                            goto_phase(PH_IDLE);
                        end else begin
                            byte_idx = byte_idx + 2'd1;
                            goto_phase(PH_BYTE_LOW);
                        end
                    end else begin
                        bit_idx = bit_idx + 3'd1;
                        goto_phase(PH_BIT_RISE);
                    end
                end
            end
            default: goto_phase(PH_IDLE);
        endcase
        r.drive_enable = (ph == PH_PRE_HIGH || ph == PH_START_LOW || ph == PH_RELEASE);
        r.drive_level  = (ph == PH_PRE_HIGH || ph == PH_RELEASE);
        r.busy_res     = (ph != PH_IDLE);
        r.done_res     = done;
        r.first_byte   = rx_bytes[0];
        r.second_byte  = rx_bytes[1];
        r.third_byte   = rx_bytes[2];
        r.timeout_seen = to_flag;
        return r;
    endfunction

    function automatic bit is_edge_wait(input phase_t p);
        return (p == PH_RESP_LOW || p == PH_RESP_HIGH || p == PH_BYTE_LOW ||
                p == PH_BIT_RISE || p == PH_BIT_FALL);
    endfunction

    function automatic bit wanted_level(input phase_t p);
        return (p == PH_RESP_HIGH || p == PH_BIT_RISE);
    endfunction

    // register word: mostly short delays, now and then a long one, junk above the field
    function automatic logic [31:0] timing_word(input logic [2:0] idx);
        logic [15:0] v;
        if (idx == REG_PRE_HIGH) begin
            v = ($urandom_range(0, 30) == 0) ? 16'($urandom_range(0, 60)) :
                                               16'($urandom_range(0, 8));
            return ($urandom & 32'hFFFF_0000) | {16'h0000, v};
        end
        v = ($urandom_range(0, 30) == 0) ? 16'($urandom_range(0, 40)) :
                                           16'($urandom_range(0, 4));
        return ($urandom & 32'hFFFF_FF00) | {24'h000000, v[7:0]};
    endfunction

    // one tick beat: sender bursts and gaps, then predict on acceptance
    task automatic send_tick(input bit st, input bit ln, input bit typed, input reading_t val);
        reading_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_len != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b000000, ln, st};
        do @(posedge aclk); while (!s_tready);
        r = sensor_step(st, ln);
        reading_q.push_back(typed ? val : r);
    endtask

    // sensor side: answers edge waits after a few ticks, random bits, some noise
    task automatic send_next();
        bit st;
        bit ln;
        if (is_edge_wait(ph) && $urandom_range(0, 9) != 0)
            ln = ($urandom_range(0, 2) == 0) ? wanted_level(ph) : !wanted_level(ph);
        else
            ln = $urandom_range(0, 1);
        st = (ph == PH_IDLE) ? ($urandom_range(0, 3) == 0) : bit'($urandom_range(0, 1));
        send_tick(st, ln, 1'b0, QUIET);
    endtask

    // finish the read in progress, starting one if idle
    task automatic run_read();
        if (ph == PH_IDLE)
            send_tick(1'b1, bit'($urandom_range(0, 1)), 1'b0, QUIET);
        while (ph != PH_IDLE)
            send_next();
    endtask

    // stop sending and wait for every expected beat
    task automatic settle_out();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reading_q.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // apb write: setup, access, then idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        cfg_val[idx] = (idx == REG_PRE_HIGH) ? word[15:0] : {8'h00, word[7:0]};
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: ready pattern by cycle window, plus one long hold-off on request
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= rx_cycle[0];
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin : check_beat
        logic [31:0] want;
        logic [31:0] fmask;
        if (aresetn && m_tvalid && m_tready) begin
            if (reading_q.size() == 0) begin
                bad_beats++;
                $display("%0t: result beat with none expected, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = {3'b000, reading_q.pop_front()};
                for (int f = 0; f < 9; f++) begin
                    fmask = (32'd1 << fld_w[f]) - 32'd1;
                    if (((want >> fld_lsb[f]) & fmask) != ((m_tdata >> fld_lsb[f]) & fmask)) begin
                        bad_beats++;
                        $display("%0t: %s expected %0h actual %0h", $time, fld_name[f],
                                 (want >> fld_lsb[f]) & fmask,
                                 (m_tdata >> fld_lsb[f]) & fmask);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int rand_sent;
        int round_no;
        int len;
        int nwr;
        logic [2:0] ri;

        // mirror starts from reset
        cfg_val[REG_PRE_HIGH]   = PRE_HIGH_RST;
        cfg_val[REG_START_LOW]  = {8'h00, START_LOW_RST};
        cfg_val[REG_RELEASE]    = {8'h00, RELEASE_RST};
        cfg_val[REG_SETTLE]     = {8'h00, SETTLE_RST};
        cfg_val[REG_RESP_DELAY] = {8'h00, RESP_DELAY_RST};
        cfg_val[REG_BYTE_LEAD]  = {8'h00, BYTE_LEAD_RST};
        cfg_val[REG_SAMPLE]     = {8'h00, SAMPLE_RST};
        cfg_val[REG_BIT_TAIL]   = {8'h00, BIT_TAIL_RST};
        ph       = PH_IDLE;
        cnt      = '0;
        bit_idx  = '0;
        byte_idx = '0;
        shreg    = '0;
        foreach (rx_bytes[i]) rx_bytes[i] = '0;
        to_flag  = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows, then finish that read with every delay at zero
        foreach (plan[i])
            send_tick(plan[i].st, plan[i].ln, plan[i].typed, plan[i].val);

        // all delays zero, high bits of each write are junk
        settle_out();
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), $urandom & ((i == REG_PRE_HIGH) ? 32'hFFFF_0000 : 32'hFFFF_FF00));
        run_read();

        // timing change in the middle of a read
        send_tick(1'b1, 1'b1, 1'b0, QUIET);
        repeat (15) send_next();
        settle_out();
        write_reg(REG_SAMPLE, 32'd3);
        write_reg(REG_BIT_TAIL, 32'd2);
        run_read();

        // longest delays with junk above each field, then short ones again mid-read
        settle_out();
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), 32'hFFFF_FFFF);
        send_tick(1'b1, 1'b1, 1'b0, QUIET);
        repeat (40) send_next();
        settle_out();
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), $urandom & ((i == REG_PRE_HIGH) ? 32'hFFFF_0000 : 32'hFFFF_FF00));
        run_read();

        // random rounds, timing rewritten between them
        rand_sent = 0;
        round_no  = 0;
        while (rand_sent < RANDOM_TICKS) begin
            settle_out();
            nwr = $urandom_range(1, 8);
            repeat (nwr) begin
                ri = 3'($urandom_range(0, 7));
                write_reg(ri, timing_word(ri));
            end
            if (round_no == 2)
                hold_req <= 1'b1;
            len = $urandom_range(80, 250);
            repeat (len) send_next();
            rand_sent = rand_sent + len;
            round_no  = round_no + 1;
        end

        settle_out();
        repeat (4) @(posedge aclk);
        if (bad_beats == 0 && reading_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/swsr_pkg.sv
rtl/single_wire_sensor_reader.sv
bench/tb_single_wire_sensor_reader.sv
